// ===== hw/rtl/tcc_pkg.sv =====
// Shared types and constants for the text console cursor controller.
// No dependencies; the modules, the checker and the testbench import this package.
package tcc_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 128;
  localparam int TAB_SPACES  = 4;
  localparam int MAX_RESULTS = 8;

  // usable screen size limits (hardware tops at 256 x 128 cells)
  localparam int COL_TOP_RAW = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
  localparam int ROW_TOP_RAW = (MAX_ROWS < 128) ? MAX_ROWS : 128;
  localparam int COL_TOP     = (COL_TOP_RAW < 1) ? 1 : COL_TOP_RAW;
  localparam int ROW_TOP     = (ROW_TOP_RAW < 1) ? 1 : ROW_TOP_RAW;

  localparam int CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int REM_W = (TAB_SPACES > 1) ? $clog2(TAB_SPACES) : 1;

  // console control bytes
  localparam logic [7:0] CH_BELL = 8'h07;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // configuration register indexes
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_FORE    = 2'd2;
  localparam logic [1:0] REG_BACK    = 2'd3;

  typedef enum logic [1:0] {
    OP_GLYPH        = 2'd0,
    OP_CLEAR_CELL   = 2'd1,
    OP_SCROLL       = 2'd2,
    OP_CLEAR_SCREEN = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_GLYPH,
    K_TAB,
    K_NEWLINE,
    K_BACKSPACE,
    K_CR,
    K_FF,
    K_BELL,
    K_SETCUR
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  code;
    logic [7:0]  set_col;
    logic [6:0]  set_row;
  } cmd_t;

  typedef struct packed {
    logic [8:0]  columns;
    logic [7:0]  rows;
    logic [23:0] fore;
    logic [23:0] back;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] cur_col;
    logic [6:0] cur_row;
  } bk_stat_t;

endpackage

// ===== hw/rtl/tcc_in_if.sv =====
// Input channel of the cursor controller: console byte or set-cursor request.
// Depends on nothing.
interface tcc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] char_code;
  logic [7:0] set_col;
  logic [6:0] set_row;

  modport source (output valid, func, char_code, set_col, set_row, input ready);
  modport sink   (input valid, func, char_code, set_col, set_row, output ready);
endinterface

// ===== hw/rtl/tcc_out_if.sv =====
// Result channel of the cursor controller: one drawing command per transfer.
// Depends on nothing.
interface tcc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  cell_col;
  logic [6:0]  cell_row;
  logic [7:0]  glyph;
  logic [23:0] ink_colour;
  logic [23:0] paper_colour;
  logic        last;

  modport source (output valid, op, cell_col, cell_row, glyph, ink_colour,
                  paper_colour, last, input ready);
  modport sink   (input valid, op, cell_col, cell_row, glyph, ink_colour,
                  paper_colour, last, output ready);
endinterface

// ===== hw/rtl/tcc_front.sv =====
// Front end: accepts input transfers and classifies them into queue commands.
// Depends on tcc_pkg and tcc_in_if.
module tcc_front (
  tcc_in_if.sink           in_item,
  input  tcc_pkg::q_stat_t q_stat,
  output logic             push,
  output tcc_pkg::cmd_t    cmd
);
  import tcc_pkg::*;

  kind_t kind;

  always_comb begin
    if (in_item.func) begin
      kind = K_SETCUR;
    end else begin
      unique case (in_item.char_code)
        CH_LF, CH_VT: kind = K_NEWLINE;
        CH_BS:        kind = K_BACKSPACE;
        CH_BELL:      kind = K_BELL;
        CH_CR:        kind = K_CR;
        CH_TAB:       kind = K_TAB;
        CH_FF:        kind = K_FF;
        default:      kind = K_GLYPH;
      endcase
    end
  end

  assign in_item.ready = !q_stat.full;
  assign push          = in_item.valid && !q_stat.full;

  assign cmd.kind    = kind;
  assign cmd.code    = in_item.char_code;
  assign cmd.set_col = in_item.set_col;
  assign cmd.set_row = in_item.set_row;

endmodule

// ===== hw/rtl/tcc_queue.sv =====
// Small command queue between the front and back ends.
// Depends on tcc_pkg.
module tcc_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tcc_pkg::cmd_t     wr_data,
  input  logic              pop,
  output tcc_pkg::cmd_t     rd_data,
  output tcc_pkg::q_stat_t  q_stat
);
  import tcc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

  assign rd_data      = mem[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CW'(DEPTH));

endmodule

// ===== hw/rtl/tcc_back.sv =====
// Back end: owns the cursor and sequences drawing commands, one per cycle
// when not stalled, into the output register. Needs tcc_pkg, tcc_out_if.
module tcc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tcc_pkg::cfg_t     cfg,
  input  tcc_pkg::cmd_t     q_data,
  input  tcc_pkg::q_stat_t  q_stat,
  output logic              pop,
  output tcc_pkg::bk_stat_t status,
  tcc_out_if.source         out_cmd
);
  import tcc_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_TAB, S_SCROLL} state_t;

  state_t           state_r, state_nxt;
  logic [7:0]       col_r, col_nxt;
  logic [6:0]       row_r, row_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_base;

  logic             out_valid_r;
  op_t              op_r;
  logic [7:0]       ocol_r, oglyph_r;
  logic [6:0]       orow_r;
  logic [23:0]      ink_r, paper_r;
  logic             last_r;

  logic [8:0]       eff_cols;
  logic [7:0]       eff_rows;
  logic [8:0]       cols_m1;
  logic [7:0]       rows_m1;
  logic [7:0]       cmax, col_s, g_col;
  logic [6:0]       rmax, row_s, g_row;
  logic             g_wrap, g_scroll;
  logic             adv, go, emit_ok, load;

  op_t              e_op;
  logic             e_valid, e_last;
  logic [7:0]       e_col, e_glyph;
  logic [6:0]       e_row;
  logic [23:0]      e_ink;
  logic [REM_W-1:0] rem_after;

  always_comb begin
    if (cfg.columns == '0)                 eff_cols = 9'd1;
    else if (cfg.columns > 9'(COL_TOP))    eff_cols = 9'(COL_TOP);
    else                                   eff_cols = cfg.columns;
    if (cfg.rows == '0)                    eff_rows = 8'd1;
    else if (cfg.rows > 8'(ROW_TOP))       eff_rows = 8'(ROW_TOP);
    else                                   eff_rows = cfg.rows;
  end

  assign cols_m1 = eff_cols - 9'd1;
  assign rows_m1 = eff_rows - 8'd1;
  assign cmax    = cols_m1[7:0];
  assign rmax    = rows_m1[6:0];

  // cursor pulled back inside a screen that may have shrunk
  assign col_s = (col_r > cmax) ? cmax : col_r;
  assign row_s = (row_r > rmax) ? rmax : row_r;

  // one printed cell: advance, wrap, maybe scroll
  assign g_wrap   = (col_s == cmax);
  assign g_scroll = g_wrap && (row_s == rmax);
  assign g_col    = g_wrap ? 8'd0 : col_s + 8'd1;
  assign g_row    = (g_wrap && !g_scroll) ? row_s + 7'd1 : row_s;

  assign adv = !out_valid_r || out_cmd.ready;
  assign go  = adv && ((state_r != S_IDLE) || !q_stat.empty);
  assign pop = adv && (state_r == S_IDLE) && !q_stat.empty;

  always_comb begin
    state_nxt = S_IDLE;
    col_nxt   = col_s;
    row_nxt   = row_s;
    rem_nxt   = rem_r;
    rem_after = '0;
    e_valid   = 1'b0;
    e_last    = 1'b1;
    e_op      = OP_GLYPH;
    e_col     = '0;
    e_row     = '0;
    e_glyph   = '0;
    e_ink     = '0;
    unique case (state_r)
      S_IDLE: begin
        unique case (q_data.kind)
          K_SETCUR: begin
            col_nxt = (q_data.set_col > cmax) ? cmax : q_data.set_col;
            row_nxt = (q_data.set_row > rmax) ? rmax : q_data.set_row;
          end
          K_CR: col_nxt = 8'd0;
          K_BELL: ;
          K_NEWLINE: begin
            col_nxt = 8'd0;
            if (row_s == rmax) begin
              e_valid = 1'b1;
              e_op    = OP_SCROLL;
            end else begin
              row_nxt = row_s + 7'd1;
            end
          end
          K_BACKSPACE: begin
            if (col_s == 8'd0) begin
              if (row_s != 7'd0) begin
                row_nxt = row_s - 7'd1;
                col_nxt = cmax;
              end
            end else begin
              col_nxt = col_s - 8'd1;
            end
            e_valid = 1'b1;
            e_op    = OP_CLEAR_CELL;
            e_col   = col_nxt;
            e_row   = row_nxt;
          end
          K_FF: begin
            col_nxt = 8'd0;
            row_nxt = 7'd0;
            e_valid = 1'b1;
            e_op    = OP_CLEAR_SCREEN;
          end
          K_GLYPH, K_TAB: begin
            rem_after = (q_data.kind == K_TAB) ? REM_W'(TAB_SPACES - 1) : '0;
            col_nxt   = g_col;
            row_nxt   = g_row;
            e_valid   = 1'b1;
            e_op      = OP_GLYPH;
            e_col     = col_s;
            e_row     = row_s;
            e_glyph   = (q_data.kind == K_TAB) ? CH_SPACE : q_data.code;
            e_ink     = cfg.fore;
            e_last    = !g_scroll && (rem_after == '0);
            rem_nxt   = rem_after;
            if (g_scroll)               state_nxt = S_SCROLL;
            else if (rem_after != '0)   state_nxt = S_TAB;
          end
          default: ;
        endcase
      end
      S_TAB: begin
        rem_after = rem_r - 1'b1;
        col_nxt   = g_col;
        row_nxt   = g_row;
        e_valid   = 1'b1;
        e_op      = OP_GLYPH;
        e_col     = col_s;
        e_row     = row_s;
        e_glyph   = CH_SPACE;
        e_ink     = cfg.fore;
        e_last    = !g_scroll && (rem_after == '0);
        rem_nxt   = rem_after;
        if (g_scroll)             state_nxt = S_SCROLL;
        else if (rem_after != '0) state_nxt = S_TAB;
      end
      S_SCROLL: begin
        e_valid   = 1'b1;
        e_op      = OP_SCROLL;
        e_last    = (rem_r == '0);
        state_nxt = (rem_r != '0) ? S_TAB : S_IDLE;
      end
      default: ;
    endcase
  end

  // results past the per-input limit are dropped; the cursor still moves
  assign cnt_base = (state_r == S_IDLE) ? '0 : cnt_r;
  assign emit_ok  = (cnt_base < CNT_W'(MAX_RESULTS));
  assign load     = go && e_valid && emit_ok;
  assign cnt_nxt  = cnt_base + CNT_W'(load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      rem_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        state_r <= state_nxt;
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        rem_r   <= rem_nxt;
        cnt_r   <= cnt_nxt;
      end
      if (adv) out_valid_r <= load;
    end
    if (load) begin
      op_r     <= e_op;
      ocol_r   <= e_col;
      orow_r   <= e_row;
      oglyph_r <= e_glyph;
      ink_r    <= e_ink;
      paper_r  <= cfg.back;
      last_r   <= e_last || (cnt_base == CNT_W'(MAX_RESULTS - 1));
    end
  end

  assign out_cmd.valid        = out_valid_r;
  assign out_cmd.op           = op_r;
  assign out_cmd.cell_col     = ocol_r;
  assign out_cmd.cell_row     = orow_r;
  assign out_cmd.glyph        = oglyph_r;
  assign out_cmd.ink_colour   = ink_r;
  assign out_cmd.paper_colour = paper_r;
  assign out_cmd.last         = last_r;

  assign status.busy    = (state_r != S_IDLE);
  assign status.cur_col = col_r;
  assign status.cur_row = row_r;

endmodule

// ===== hw/rtl/text_console_cursor_controller.sv =====
// Top level of the text console cursor controller: configuration registers,
// front end, command queue and back end. Depends on tcc_pkg and both channel interfaces.
//
//   channel   dir  handshake      carries
//   in_item   in   valid/ready    func, char_code, set_col, set_row
//   out_cmd   out  valid/ready    op, cell_col, cell_row, glyph, colours, last
//   cfg_*     in   cfg_we only    cfg_index, cfg_data (24 bits)
//
// The back-end sequencer issues one command per cycle unless out ready stalls it:
// a printed byte gives its glyph and, if it wraps past the last row, a scroll; a tab
// gives TAB_SPACES blank glyphs, each maybe with a scroll; pure moves draw nothing.
// An accepted item is written to the queue, then its first result to the output register.
// Synchronous active-low reset: cursor (0,0), registers to defaults, no sweep.
// out ready low with a result pending freezes the back end; the front keeps
// taking items until the queue of QUEUE_DEPTH commands is full.
module text_console_cursor_controller #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  tcc_in_if.sink      in_item,
  tcc_out_if.source   out_cmd
);
  import tcc_pkg::*;

  logic [8:0]  columns_r;
  logic [7:0]  rows_r;
  logic [23:0] fore_r, back_r;
  cfg_t        cfg;
  cmd_t        push_cmd, q_data;
  q_stat_t     q_stat;
  bk_stat_t    bk_stat;
  logic        push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      columns_r <= 9'd80;
      rows_r    <= 8'd25;
      fore_r    <= 24'hFFFFFF;
      back_r    <= 24'h000000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLUMNS: columns_r <= cfg_data[8:0];
        REG_ROWS:    rows_r    <= cfg_data[7:0];
        REG_FORE:    fore_r    <= cfg_data;
        REG_BACK:    back_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.columns = columns_r;
  assign cfg.rows    = rows_r;
  assign cfg.fore    = fore_r;
  assign cfg.back    = back_r;

  tcc_front u_front (
    .in_item (in_item),
    .q_stat  (q_stat),
    .push    (push),
    .cmd     (push_cmd)
  );

  tcc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_cmd),
    .pop     (pop),
    .rd_data (q_data),
    .q_stat  (q_stat)
  );

  tcc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_data  (q_data),
    .q_stat  (q_stat),
    .pop     (pop),
    .status  (bk_stat),
    .out_cmd (out_cmd)
  );

  // a non-final result is pending only while the sequencer is mid-input
  a_partial_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_cmd.valid && !out_cmd.last |-> bk_stat.busy)
    else $error("non-final result with idle sequencer");

  // an accepted transfer is in the queue at the next edge
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_item.valid && in_item.ready |=> !q_stat.empty)
    else $error("accepted item missing from queue");

  // scroll and clear screen leave the cursor at column 0 until the next command
  a_scroll_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_cmd.valid && (out_cmd.op == OP_SCROLL) |-> bk_stat.cur_col == 8'd0)
    else $error("cursor not at column 0 after scroll");

  a_clear_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_cmd.valid && (out_cmd.op == OP_CLEAR_SCREEN)
      |-> (bk_stat.cur_col == 8'd0) && (bk_stat.cur_row == 7'd0))
    else $error("cursor not home after clear screen");

endmodule

// ===== sim/tcc_cmd_checker.sv =====
`timescale 1ns / 1ps
// Draw-command checker for the text console cursor controller: mirrors the
// registers and the cursor cell, predicts the commands of each item, compares.
// Depends on tcc_pkg and the tcc_in_if / tcc_out_if channel interfaces.
module tcc_cmd_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  tcc_in_if           in_ch,
  tcc_out_if          out_ch,
  output int          fail_count,
  output int          cmds_pending
);
  import tcc_pkg::*;

  typedef struct packed {
    op_t         op;
    logic [7:0]  cell_col;
    logic [6:0]  cell_row;
    logic [7:0]  glyph;
    logic [23:0] ink;
    logic [23:0] paper;
    logic        last;
  } draw_cmd_t;

  logic [8:0]  columns_reg;
  logic [7:0]  rows_reg;
  logic [23:0] fore_reg;
  logic [23:0] back_reg;

  int cur_col;
  int cur_row;
  int cols_used;
  int rows_used;

  draw_cmd_t cmds_due[$];
  draw_cmd_t item_cmds[$];

  function automatic int limit_size(int v, int top);
    if (v < 1) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic void push_cmd(op_t op, int col, int row, int code, logic [23:0] ink);
    draw_cmd_t c;
    // commands past the per-item cap are dropped, the cursor still moves
    if (item_cmds.size() >= MAX_RESULTS) return;
    c.op       = op;
    c.cell_col = col[7:0];
    c.cell_row = row[6:0];
    c.glyph    = code[7:0];
    c.ink      = ink;
    c.paper    = back_reg;
    c.last     = 1'b0;
    item_cmds.push_back(c);
  endfunction

  function automatic void next_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= rows_used) begin
      push_cmd(OP_SCROLL, 0, 0, 0, 24'h0);
      cur_row = rows_used - 1;
    end
  endfunction

  function automatic void put_char(logic [7:0] code);
    push_cmd(OP_GLYPH, cur_col, cur_row, int'(code), fore_reg);
    cur_col++;
    if (cur_col >= cols_used) next_row();
  endfunction

  function automatic void track_cursor(logic func, logic [7:0] code, logic [7:0] scol,
                                       logic [6:0] srow);
    cols_used = limit_size(int'(columns_reg), COL_TOP);
    rows_used = limit_size(int'(rows_reg), ROW_TOP);
    item_cmds.delete();
    // a shrunken screen pulls the cursor back inside
    if (cur_col > cols_used - 1) cur_col = cols_used - 1;
    if (cur_row > rows_used - 1) cur_row = rows_used - 1;
    if (func) begin
      cur_col = (int'(scol) > cols_used - 1) ? cols_used - 1 : int'(scol);
      cur_row = (int'(srow) > rows_used - 1) ? rows_used - 1 : int'(srow);
      return;
    end
    case (code)
      CH_LF, CH_VT: next_row();
      CH_BS: begin
        if (cur_col == 0) begin
          if (cur_row > 0) begin
            cur_row--;
            cur_col = cols_used - 1;
          end
        end else begin
          cur_col--;
        end
        push_cmd(OP_CLEAR_CELL, cur_col, cur_row, 0, 24'h0);
      end
      CH_BELL: ;
      CH_CR: cur_col = 0;
      CH_TAB: begin
        for (int i = 0; i < TAB_SPACES; i++) put_char(CH_SPACE);
      end
      CH_FF: begin
        push_cmd(OP_CLEAR_SCREEN, 0, 0, 0, 24'h0);
        cur_col = 0;
        cur_row = 0;
      end
      default: put_char(code);
    endcase
    if (item_cmds.size() > 0) item_cmds[item_cmds.size() - 1].last = 1'b1;
    foreach (item_cmds[i]) cmds_due.push_back(item_cmds[i]);
  endfunction

  function automatic string show_cmd(draw_cmd_t c);
    return $sformatf("op=%0d col=%0d row=%0d glyph=%02h ink=%06h paper=%06h last=%0b",
                     c.op, c.cell_col, c.cell_row, c.glyph, c.ink, c.paper, c.last);
  endfunction

  always @(posedge clk) begin
    draw_cmd_t got;
    draw_cmd_t want;
    string     bad;
    if (!rst_n) begin
      columns_reg = 9'd80;
      rows_reg    = 8'd25;
      fore_reg    = 24'hFFFFFF;
      back_reg    = 24'h000000;
      cur_col     = 0;
      cur_row     = 0;
      cmds_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COLUMNS: columns_reg = cfg_data[8:0];
          REG_ROWS:    rows_reg    = cfg_data[7:0];
          REG_FORE:    fore_reg    = cfg_data;
          REG_BACK:    back_reg    = cfg_data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.op       = op_t'(out_ch.op);
        got.cell_col = out_ch.cell_col;
        got.cell_row = out_ch.cell_row;
        got.glyph    = out_ch.glyph;
        got.ink      = out_ch.ink_colour;
        got.paper    = out_ch.paper_colour;
        got.last     = out_ch.last;
        if (cmds_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("command with none expected: %s", show_cmd(got));
        end else begin
          want = cmds_due.pop_front();
          bad  = "";
          if (got.op !== want.op) bad = {bad, " op"};
          if (got.cell_col !== want.cell_col) bad = {bad, " cell_col"};
          if (got.cell_row !== want.cell_row) bad = {bad, " cell_row"};
          if (got.glyph !== want.glyph) bad = {bad, " glyph"};
          if (got.ink !== want.ink) bad = {bad, " ink_colour"};
          if (got.paper !== want.paper) bad = {bad, " paper_colour"};
          if (got.last !== want.last) bad = {bad, " last"};
          if (bad != "") begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch in%s", bad);
              $display("  expected %s", show_cmd(want));
              $display("  actual   %s", show_cmd(got));
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        track_cursor(in_ch.func, in_ch.char_code, in_ch.set_col, in_ch.set_row);
    end
    cmds_pending = cmds_due.size();
  end

endmodule

// ===== sim/text_console_cursor_controller_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the text console cursor controller: clock, reset, register
// writes, console traffic and output stalls; verdict comes from tcc_cmd_checker.
// Depends on tcc_pkg, the channel interfaces, the RTL and tcc_cmd_checker.
module text_console_cursor_controller_tb;
  import tcc_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 33;
  localparam int NUM_PHASES    = 7;

  localparam logic [7:0] CTRL_CODES [7] = '{CH_BELL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF,
                                            CH_CR};

  typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE} rx_mode_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  int fail_count;
  int cmds_pending;
  int idle_cycles = 0;
  int burst_left  = 0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;

  tcc_in_if  in_ch();
  tcc_out_if out_ch();

  text_console_cursor_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_ch),
    .out_cmd   (out_ch)
  );

  tcc_cmd_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .cmds_pending (cmds_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output stalls; one long hold-off on request so the queue fills up
  initial begin
    int       seg;
    rx_mode_t mode;
    out_ch.ready = 1'b0;
    forever begin
      seg  = $urandom_range(4, 40);
      mode = rx_mode_t'($urandom_range(0, 2));
      repeat (seg) begin
        @(negedge clk);
        if (hold_req && !hold_done) begin
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_done = 1'b1;
        end else begin
          case (mode)
            RX_ALWAYS: out_ch.ready <= 1'b1;
            RX_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
            default:   out_ch.ready <= 1'b1;
          endcase
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_screen(int cols, int rows, logic [23:0] fore, logic [23:0] back);
    write_reg(REG_COLUMNS, cols[23:0]);
    write_reg(REG_ROWS, rows[23:0]);
    write_reg(REG_FORE, fore);
    write_reg(REG_BACK, back);
  endtask

  task automatic send_item(logic func, logic [7:0] code, logic [7:0] scol, logic [6:0] srow);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.func      <= func;
    in_ch.char_code <= code;
    in_ch.set_col   <= scol;
    in_ch.set_row   <= srow;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_char(logic [7:0] code);
    send_item(1'b0, code, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
  endtask

  task automatic set_cursor(logic [7:0] col, logic [6:0] row);
    send_item(1'b1, 8'($urandom_range(0, 255)), col, row);
  endtask

  task automatic random_item();
    logic       func;
    logic [7:0] code;
    func = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 99) < 30) code = CTRL_CODES[$urandom_range(0, 6)];
    else code = 8'($urandom_range(0, 255));
    send_item(func, code, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
  endtask

  // all results in, then let result-less items drain before touching registers
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    wait (cmds_pending == 0 && (hold_done || !hold_req));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_COLUMNS;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.func      = 1'b0;
    in_ch.char_code = '0;
    in_ch.set_col   = '0;
    in_ch.set_row   = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset screen 80 x 25
    send_char(8'h41);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_TAB);
    send_char(CH_CR);
    send_char(CH_LF);
    send_char(CH_VT);
    send_char(CH_BS);        // column 0: wraps to end of previous row
    send_char(CH_BELL);
    set_cursor(8'd0, 7'd0);
    send_char(CH_BS);        // home cell stays and is blanked
    send_char(CH_FF);
    set_cursor(8'hFF, 7'h7F); // saturates to the last cell
    send_char(8'h5A);        // wrap past the last row scrolls
    send_char(CH_LF);
    set_cursor(8'd77, 7'd24);
    send_char(CH_TAB);       // wraps and scrolls after the third space

    // single cell: a tab gives the full eight commands
    settle();
    set_screen(1, 1, 24'h000000, 24'hFFFFFF);
    send_char(CH_TAB);
    send_char(CH_LF);
    send_char(CH_BS);
    send_char(CH_FF);

    // cursor left outside a shrunken screen
    settle();
    set_screen(256, 128, 24'h123456, 24'hABCDEF);
    set_cursor(8'd255, 7'd127);
    send_char(8'h80);
    set_cursor(8'd200, 7'd100);
    settle();
    set_screen(10, 5, 24'hFFFFFF, 24'h000000);
    send_char(8'h2A);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: set_screen(80, 25, 24'($urandom), 24'($urandom));
        1: set_screen(1, 1, 24'($urandom), 24'($urandom));
        2: set_screen(0, 0, 24'($urandom), 24'($urandom));        // clamps up to 1 x 1
        3: set_screen(511, 255, 24'h000000, 24'h000000);          // clamps to the hard top
        4: set_screen(256, 128, 24'hFFFFFF, 24'hFFFFFF);
        5: set_screen($urandom_range(2, 12), $urandom_range(1, 6), 24'($urandom),
                      24'($urandom));
        default: set_screen($urandom_range(1, 20), $urandom_range(1, 8), 24'($urandom),
                            24'($urandom));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == NUM_PHASES - 1 && i == 4) hold_req = 1'b1;
        random_item();
      end
    end

    settle();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== text_console_cursor_controller.f =====
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_in_if.sv
hw/rtl/tcc_out_if.sv
hw/rtl/tcc_front.sv
hw/rtl/tcc_queue.sv
hw/rtl/tcc_back.sv
hw/rtl/text_console_cursor_controller.sv
sim/tcc_cmd_checker.sv
sim/text_console_cursor_controller_tb.sv
